// ----- sv/bsfr_pkg.sv -----
// Package for the byte-stuffed frame receiver: shared types, codes and constants.
// It has no dependencies. All other files of the block refer to it by scoped names.
`default_nettype none

package bsfr_pkg;

   // This is the largest payload count that a frame reports. The count saturates here.
   localparam int MAX_PAYLOAD = 4095;
   localparam int COUNT_WIDTH = 12;
   localparam int COUNT_FIELD_MAX = (1 << COUNT_WIDTH) - 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT =
      COUNT_WIDTH'((MAX_PAYLOAD < COUNT_FIELD_MAX) ? MAX_PAYLOAD : COUNT_FIELD_MAX);

   localparam logic [7:0] STUFF_MASK = 8'h20;
   localparam logic [7:0] CTRL_ZERO  = 8'h00;
   localparam logic [7:0] CTRL_ONE   = 8'h40;

   // These are the register indexes on the configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLAG    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADDRESS = 2'd2;

   localparam logic [7:0] FLAG_RESET    = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET  = 8'h7D;
   localparam logic [7:0] ADDRESS_RESET = 8'h03;

   // These are the kinds of result items.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // These are the status codes of the frame end report.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BCC2_BAD  = 2'd1;
   localparam logic [1:0] STATUS_NO_DATA   = 2'd2;
   localparam logic [1:0] STATUS_ESC_FLAG  = 2'd3;

   typedef struct packed {
      logic [7:0] flag_value;
      logic [7:0] escape_value;
      logic [7:0] address_value;
   } cfg_type;

   typedef struct packed {
      logic                   item_kind;
      logic [7:0]             data_byte;
      logic [7:0]             control_field;
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] payload_count;
      logic                   last;
   } rsp_type;

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_FLAG = 5'b00010,
      PH_ADDR = 5'b00100,
      PH_CTRL = 5'b01000,
      PH_BODY = 5'b10000
   } phase_type;

endpackage

`default_nettype wire

// ----- sv/bsfr_if.sv -----
// Channel interfaces of the byte-stuffed frame receiver: request, response and register write.
// It depends on bsfr_pkg for field widths.
`default_nettype none

interface bsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            item_kind;
   logic [7:0]                      data_byte;
   logic [7:0]                      control_field;
   logic [1:0]                      status;
   logic [bsfr_pkg::COUNT_WIDTH-1:0] payload_count;
   logic                            last;

   modport source (output valid, output item_kind, output data_byte, output control_field,
                   output status, output payload_count, output last, input ready);
   modport sink   (input valid, input item_kind, input data_byte, input control_field,
                   input status, input payload_count, input last, output ready);
endinterface

interface bsfr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [7:0]                          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/bsfr_csr.sv -----
// Configuration registers of the byte-stuffed frame receiver (flag, escape, address).
// It depends on bsfr_pkg.
`default_nettype none

module bsfr_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] wr_index,
   input  wire logic [7:0]                           wr_data,
   output bsfr_pkg::cfg_type                         cfg
);

   bsfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            bsfr_pkg::CSR_FLAG:    cfg_in.flag_value    = wr_data;
            bsfr_pkg::CSR_ESCAPE:  cfg_in.escape_value  = wr_data;
            bsfr_pkg::CSR_ADDRESS: cfg_in.address_value = wr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value    <= bsfr_pkg::FLAG_RESET;
         cfg_ff.escape_value  <= bsfr_pkg::ESCAPE_RESET;
         cfg_ff.address_value <= bsfr_pkg::ADDRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- sv/bsfr_engine.sv -----
// Frame engine: header checks, destuffing, one-byte hold for BCC2, parity and count.
// It depends on bsfr_pkg. It processes one registered byte per step.
`default_nettype none

module bsfr_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bsfr_pkg::cfg_type cfg,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   output logic                   res_valid,
   output bsfr_pkg::rsp_type      res
);

   bsfr_pkg::phase_type               phase_ff, phase_in;
   logic [7:0]                        control_ff, control_in;
   logic [7:0]                        held_ff, held_in;
   logic                              held_valid_ff, held_valid_in;
   logic                              escape_ff, escape_in;
   logic [7:0]                        parity_ff, parity_in;
   logic [bsfr_pkg::COUNT_WIDTH-1:0]  count_ff, count_in;

   logic       take;
   logic [7:0] take_byte;
   logic       is_flag;

   assign is_flag = (rx_byte == cfg.flag_value);

   always_comb begin
      phase_in      = phase_ff;
      control_in    = control_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      escape_in     = escape_ff;
      parity_in     = parity_ff;
      count_in      = count_ff;
      take          = 1'b0;
      take_byte     = rx_byte;
      res_valid     = 1'b0;
      res           = '0;

      case (phase_ff)
         bsfr_pkg::PH_HUNT: begin
            if (is_flag) phase_in = bsfr_pkg::PH_FLAG;
         end
         bsfr_pkg::PH_FLAG: begin
            // The address check wins over the flag check.
            if (rx_byte == cfg.address_value) phase_in = bsfr_pkg::PH_ADDR;
            else if (!is_flag) phase_in = bsfr_pkg::PH_HUNT;
         end
         bsfr_pkg::PH_ADDR: begin
            if (rx_byte == bsfr_pkg::CTRL_ZERO || rx_byte == bsfr_pkg::CTRL_ONE) begin
               control_in = rx_byte;
               phase_in   = bsfr_pkg::PH_CTRL;
            end else if (is_flag) begin
               phase_in = bsfr_pkg::PH_FLAG;
            end else begin
               phase_in = bsfr_pkg::PH_HUNT;
            end
         end
         bsfr_pkg::PH_CTRL: begin
            if (rx_byte == (cfg.address_value ^ control_ff)) begin
               phase_in      = bsfr_pkg::PH_BODY;
               held_in       = '0;
               held_valid_in = 1'b0;
               escape_in     = 1'b0;
               parity_in     = '0;
               count_in      = '0;
            end else if (is_flag) begin
               phase_in = bsfr_pkg::PH_FLAG;
            end else begin
               phase_in = bsfr_pkg::PH_HUNT;
            end
         end
         bsfr_pkg::PH_BODY: begin
            if (is_flag) begin
               res_valid         = 1'b1;
               res.item_kind     = bsfr_pkg::KIND_END;
               res.control_field = control_ff;
               res.payload_count = count_ff;
               res.last          = 1'b1;
               if (escape_ff) res.status = bsfr_pkg::STATUS_ESC_FLAG;
               else if (!held_valid_ff) res.status = bsfr_pkg::STATUS_NO_DATA;
               else if (held_ff == parity_ff) res.status = bsfr_pkg::STATUS_OK;
               else res.status = bsfr_pkg::STATUS_BCC2_BAD;
               phase_in      = bsfr_pkg::PH_HUNT;
               held_valid_in = 1'b0;
               escape_in     = 1'b0;
            end else if (escape_ff) begin
               escape_in = 1'b0;
               take      = 1'b1;
               take_byte = rx_byte ^ bsfr_pkg::STUFF_MASK;
            end else if (rx_byte == cfg.escape_value) begin
               escape_in = 1'b1;
            end else begin
               take = 1'b1;
            end
         end
         default: phase_in = bsfr_pkg::PH_HUNT;
      endcase

      // A new body byte pushes the held byte out as payload.
      if (take) begin
         if (held_valid_ff) begin
            parity_in = parity_ff ^ held_ff;
            if (count_ff < bsfr_pkg::COUNT_LIMIT) begin
               count_in = count_ff + bsfr_pkg::COUNT_WIDTH'(1);
            end
            res_valid         = 1'b1;
            res.item_kind     = bsfr_pkg::KIND_DATA;
            res.data_byte     = held_ff;
            res.control_field = control_ff;
            res.status        = bsfr_pkg::STATUS_OK;
            res.payload_count = count_in;
            res.last          = 1'b0;
         end
         held_in       = take_byte;
         held_valid_in = 1'b1;
      end

      if (!step) res_valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bsfr_pkg::PH_HUNT;
         control_ff    <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         escape_ff     <= 1'b0;
         parity_ff     <= '0;
         count_ff      <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         control_ff    <= control_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         escape_ff     <= escape_in;
         parity_ff     <= parity_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/bsfr_out_buf.sv -----
// Two-entry registered output buffer that decouples the response side from the engine.
// It depends on bsfr_pkg.
`default_nettype none

module bsfr_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bsfr_pkg::rsp_type push_data,
   output logic                   not_full,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bsfr_pkg::rsp_type      out_data
);

   bsfr_pkg::rsp_type entry_ff [2];
   bsfr_pkg::rsp_type entry_in [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       pop;

   assign not_full  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (pop) rd_ptr_in = ~rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/byte_stuffed_frame_receiver.sv -----
// Top level of the byte-stuffed frame receiver. It depends on bsfr_pkg, the interfaces in
// bsfr_if, and the modules bsfr_csr, bsfr_engine and bsfr_out_buf.
//
// The receiver takes one raw serial byte per request and sustains one request per clock
// cycle while the output buffer is not full. A byte is captured in an input register.
// Once the output buffer has a free slot, the frame engine updates its state in one pass
// of logic and writes any response into the two-entry output buffer, which registers it.
// The engine hunts for the flag byte, then checks the address byte, a control byte of
// 0x00 or 0x40, and BCC1. It destuffs body bytes and holds each one back by one byte,
// because the byte before the closing flag is BCC2. It sends every released byte as a
// payload response with the running count. At the closing flag it sends a frame end report
// with the status and the count. The request side stalls only when the output buffer is
// full, so a consumer that takes one response per cycle never slows the stream. The three
// configuration registers have indexes 0 for flag, 1 for escape and 2 for address. Writes
// to them are always accepted and are registered in bsfr_csr. A write to index 3 is ignored.
`default_nettype none

module byte_stuffed_frame_receiver (
   input  wire logic  clock,
   input  wire logic  reset,
   bsfr_req_if.sink   req_if,
   bsfr_rsp_if.source rsp_if,
   bsfr_csr_if.sink   csr_if
);

   bsfr_pkg::cfg_type cfg;
   bsfr_pkg::rsp_type eng_res;
   bsfr_pkg::rsp_type buf_data;
   logic              eng_res_valid;
   logic              buf_not_full;
   logic              step;

   // This is the input register. It holds one accepted request until the engine consumes it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       req_take;

   // The engine steps whenever a byte is waiting and the buffer has a free slot. The
   // ready signal depends only on registered state, so there is no combinational path
   // from the response side back to the request side.
   assign step          = in_valid_ff && buf_not_full;
   assign req_if.ready  = !in_valid_ff || buf_not_full;
   assign req_take      = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (step) in_valid_in = 1'b0;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // Configuration writes are only expected while the receiver is idle.
   assign csr_if.ready = 1'b1;

   bsfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   bsfr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .res_valid (eng_res_valid),
      .res       (eng_res)
   );

   bsfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_res_valid),
      .push_data (eng_res),
      .not_full  (buf_not_full),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (buf_data)
   );

   assign rsp_if.item_kind     = buf_data.item_kind;
   assign rsp_if.data_byte     = buf_data.data_byte;
   assign rsp_if.control_field = buf_data.control_field;
   assign rsp_if.status        = buf_data.status;
   assign rsp_if.payload_count = buf_data.payload_count;
   assign rsp_if.last          = buf_data.last;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for byte_stuffed_frame_receiver: frame stimulus, a per-byte frame decoder
// and response checking, all in this top module. It depends on bsfr_pkg, the channel
// interfaces of bsfr_if and the receiver RTL.

module tb;

   // Index 3 has no register behind it, so a write to it must change nothing.
   localparam logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   // The drain wait covers a byte that is still in the receiver's pipeline but causes no
   // response.
   localparam int DRAIN_CYCLES    = 8;
   localparam int IDLE_WAIT_LIMIT = 200000;

   // The response side stops once for a long stretch after this many requests.
   localparam int HOLD_TRIGGER = 150;
   localparam int HOLD_CYCLES  = 300;

   logic clock;
   logic reset;

   bsfr_req_if req_if ();
   bsfr_rsp_if rsp_if ();
   bsfr_csr_if csr_if ();

   byte_stuffed_frame_receiver dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // This is the bench's copy of the register settings and of the frame decoder state.
   bsfr_pkg::cfg_type                line_cfg;
   bsfr_pkg::phase_type              decode_phase;
   logic [7:0]                       frame_ctl;
   logic [7:0]                       held_byte;
   logic                             held_valid;
   logic                             escape_pending;
   logic [7:0]                       payload_xor;
   logic [bsfr_pkg::COUNT_WIDTH-1:0] delivered_count;

   // Decoded responses wait here, oldest first, until the receiver sends them.
   bsfr_pkg::rsp_type due_frame_rsp[$];
   // Raw line bytes wait here until the request driver sends them.
   logic [7:0] tx_bytes[$];

   int unsigned bytes_queued;
   int unsigned bytes_accepted;
   int          req_gap;
   int          rsp_gap;
   bit          req_idle_on;
   bit          rsp_idle_on;
   int          hold_left;
   bit          hold_done;
   int          errors;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gaps are mostly zero or short, with the odd long one.
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------------------
   // Frame decoder. Each accepted request byte goes through here exactly once, at the
   // clock edge that accepts it, and any response it causes joins due_frame_rsp.
   // ------------------------------------------------------------------------------------

   function automatic void push_due(input logic kind, input logic [7:0] data,
                                    input logic [1:0] stat);
      bsfr_pkg::rsp_type r;
      r.item_kind     = kind;
      r.data_byte     = data;
      r.control_field = frame_ctl;
      r.status        = stat;
      r.payload_count = delivered_count;
      r.last          = (kind == bsfr_pkg::KIND_END);
      due_frame_rsp.push_back(r);
   endfunction

   // A new body byte pushes the previously held one out as payload. The newest byte is
   // held back since it may turn out to be BCC2.
   function automatic void release_held(input logic [7:0] d);
      if (held_valid) begin
         payload_xor = payload_xor ^ held_byte;
         if (delivered_count < bsfr_pkg::COUNT_LIMIT) begin
            delivered_count = delivered_count + bsfr_pkg::COUNT_WIDTH'(1);
         end
         push_due(bsfr_pkg::KIND_DATA, held_byte, bsfr_pkg::STATUS_OK);
      end
      held_byte  = d;
      held_valid = 1'b1;
   endfunction

   function automatic void decode_rx_byte(input logic [7:0] rx);
      logic [1:0] stat;
      case (decode_phase)
         bsfr_pkg::PH_HUNT: begin
            if (rx == line_cfg.flag_value) decode_phase = bsfr_pkg::PH_FLAG;
         end
         bsfr_pkg::PH_FLAG: begin
            // The address compare comes first, so an address equal to the flag still
            // moves the header on.
            if (rx == line_cfg.address_value) decode_phase = bsfr_pkg::PH_ADDR;
            else if (rx != line_cfg.flag_value) decode_phase = bsfr_pkg::PH_HUNT;
         end
         bsfr_pkg::PH_ADDR: begin
            if (rx == bsfr_pkg::CTRL_ZERO || rx == bsfr_pkg::CTRL_ONE) begin
               frame_ctl    = rx;
               decode_phase = bsfr_pkg::PH_CTRL;
            end else if (rx == line_cfg.flag_value) begin
               decode_phase = bsfr_pkg::PH_FLAG;
            end else begin
               decode_phase = bsfr_pkg::PH_HUNT;
            end
         end
         bsfr_pkg::PH_CTRL: begin
            if (rx == (line_cfg.address_value ^ frame_ctl)) begin
               decode_phase    = bsfr_pkg::PH_BODY;
               held_byte       = 8'h00;
               held_valid      = 1'b0;
               escape_pending  = 1'b0;
               payload_xor     = 8'h00;
               delivered_count = '0;
            end else if (rx == line_cfg.flag_value) begin
               decode_phase = bsfr_pkg::PH_FLAG;
            end else begin
               decode_phase = bsfr_pkg::PH_HUNT;
            end
         end
         bsfr_pkg::PH_BODY: begin
            if (rx == line_cfg.flag_value) begin
               if (escape_pending) stat = bsfr_pkg::STATUS_ESC_FLAG;
               else if (!held_valid) stat = bsfr_pkg::STATUS_NO_DATA;
               else if (held_byte == payload_xor) stat = bsfr_pkg::STATUS_OK;
               else stat = bsfr_pkg::STATUS_BCC2_BAD;
               push_due(bsfr_pkg::KIND_END, 8'h00, stat);
               decode_phase   = bsfr_pkg::PH_HUNT;
               held_valid     = 1'b0;
               escape_pending = 1'b0;
            end else if (escape_pending) begin
               // Whatever follows an escape, apart from a flag, is data, even a second escape.
               escape_pending = 1'b0;
               release_held(rx ^ bsfr_pkg::STUFF_MASK);
            end else if (rx == line_cfg.escape_value) begin
               escape_pending = 1'b1;
            end else begin
               release_held(rx);
            end
         end
         default: decode_phase = bsfr_pkg::PH_HUNT;
      endcase
   endfunction

   // ------------------------------------------------------------------------------------
   // Request driver. It offers the bytes of tx_bytes in order, with random gaps while
   // req_idle_on is set, and decodes each byte at the edge where the receiver takes it.
   // ------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            decode_rx_byte(req_if.rx_byte);
            bytes_accepted++;
         end
         // A new byte may go out only when nothing is on offer or the offer was taken.
         if (!req_if.valid || req_if.ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= tx_bytes.pop_front();
               req_gap = pick_gap(req_idle_on);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Response monitor. Every response taken is compared field by field with the oldest
   // decoded response. Ready drops at random while rsp_idle_on is set, and for one long hold
   // that fills the receiver's output buffer and stalls its request side.
   // ------------------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [11:0] want,
                                       input logic [11:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      bsfr_pkg::rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_frame_rsp.size() == 0) begin
               $display("%0t: response with none expected, kind %b data %h status %0d",
                        $time, rsp_if.item_kind, rsp_if.data_byte, rsp_if.status);
               errors++;
            end else begin
               want = due_frame_rsp.pop_front();
               check_field("item_kind", 12'(want.item_kind), 12'(rsp_if.item_kind));
               check_field("data_byte", 12'(want.data_byte), 12'(rsp_if.data_byte));
               check_field("control_field", 12'(want.control_field),
                           12'(rsp_if.control_field));
               check_field("status", 12'(want.status), 12'(rsp_if.status));
               check_field("payload_count", want.payload_count, rsp_if.payload_count);
               check_field("last", 12'(want.last), 12'(rsp_if.last));
            end
            rsp_gap = pick_gap(rsp_idle_on);
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // The long response hold is counted here, once per run, while requests keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_TRIGGER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------------------
   // Stimulus building. Frames are built from the current register settings, which only
   // change while the receiver is idle.
   // ------------------------------------------------------------------------------------

   task automatic send(input logic [7:0] b);
      tx_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Body bytes that look like a flag or an escape go out escaped.
   task automatic send_stuffed(input logic [7:0] b);
      if (b == line_cfg.flag_value || b == line_cfg.escape_value) begin
         send(line_cfg.escape_value);
         send(b ^ bsfr_pkg::STUFF_MASK);
      end else begin
         send(b);
      end
   endtask

   task automatic send_header(input logic [7:0] ctl);
      send(line_cfg.flag_value);
      send(line_cfg.address_value);
      send(ctl);
      send(line_cfg.address_value ^ ctl);
   endtask

   task automatic send_frame(input logic [7:0] ctl, input logic [7:0] payload[$],
                             input bit bad_check);
      logic [7:0] check;
      check = 8'h00;
      send_header(ctl);
      foreach (payload[i]) begin
         check = check ^ payload[i];
         send_stuffed(payload[i]);
      end
      if (bad_check) check = check ^ 8'($urandom_range(1, 255));
      send_stuffed(check);
      send(line_cfg.flag_value);
   endtask

   // Payload bytes are biased toward the two values that need stuffing.
   function automatic logic [7:0] random_payload_byte();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return line_cfg.flag_value;
      if (r == 1) return line_cfg.escape_value;
      return 8'($urandom);
   endfunction

   function automatic int random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 8);
      if (r < 95) return $urandom_range(9, 30);
      return $urandom_range(31, 80);
   endfunction

   // Most sequences are well-formed frames with random content. The rest are line noise
   // and frames broken in each of the ways the receiver must recover from.
   task automatic queue_random_sequence();
      logic [7:0] payload[$];
      logic [7:0] ctl;
      logic [7:0] b;
      int         pick;
      pick = $urandom_range(0, 99);
      ctl  = ($urandom_range(0, 1) != 0) ? bsfr_pkg::CTRL_ONE : bsfr_pkg::CTRL_ZERO;
      if (pick < 60) begin
         repeat (random_length()) payload.push_back(random_payload_byte());
         send_frame(ctl, payload, $urandom_range(0, 9) == 0);
      end else if (pick < 68) begin
         repeat ($urandom_range(1, 8)) send(8'($urandom));
      end else if (pick < 72) begin
         send(line_cfg.flag_value);
         send(line_cfg.address_value ^ 8'($urandom_range(1, 255)));
      end else if (pick < 76) begin
         b = 8'($urandom);
         if (b == bsfr_pkg::CTRL_ZERO || b == bsfr_pkg::CTRL_ONE) b = b ^ 8'h01;
         send(line_cfg.flag_value);
         send(line_cfg.address_value);
         send(b);
      end else if (pick < 80) begin
         send(line_cfg.flag_value);
         send(line_cfg.address_value);
         send(ctl);
         send(line_cfg.address_value ^ ctl ^ 8'($urandom_range(1, 255)));
      end else if (pick < 86) begin
         // The flag that opens the frame lands where control or BCC1 was due.
         send(line_cfg.flag_value);
         send(line_cfg.address_value);
         if ($urandom_range(0, 1) != 0) send(ctl);
         repeat ($urandom_range(0, 4)) payload.push_back(random_payload_byte());
         send_frame(ctl, payload, 1'b0);
      end else if (pick < 90) begin
         send_header(ctl);
         repeat (random_length()) send_stuffed(random_payload_byte());
         send(line_cfg.escape_value);
         send(line_cfg.flag_value);
      end else if (pick < 94) begin
         send_header(ctl);
         send(line_cfg.flag_value);
      end else begin
         send_header(ctl);
         send(line_cfg.escape_value);
         send(line_cfg.escape_value);
         repeat (random_length()) send_stuffed(random_payload_byte());
         send(line_cfg.flag_value);
      end
   endtask

   // This waits until every queued byte is taken and every decoded response has come
   // back, then lets the pipeline empty. A receiver that stops answering is reported here.
   task automatic wait_idle();
      int waited;
      waited = 0;
      while ((bytes_accepted != bytes_queued || due_frame_rsp.size() != 0) &&
             waited < IDLE_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= IDLE_WAIT_LIMIT) begin
         $display("%0t: %0d responses still expected, %0d requests not taken", $time,
                  due_frame_rsp.size(), bytes_queued - bytes_accepted);
         errors++;
         due_frame_rsp.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_phase(input int unsigned target);
      int unsigned start;
      start = bytes_queued;
      while (bytes_queued - start < target) queue_random_sequence();
      wait_idle();
   endtask

   // All three registers are written back to back with valid held high, optionally
   // followed by a write to the unused index. The bench copy changes at each accepted write.
   task automatic load_config(input bsfr_pkg::cfg_type next_cfg, input bit poke_unused);
      logic [bsfr_pkg::CSR_INDEX_WIDTH-1:0] idx[$];
      logic [7:0]                           val[$];
      idx.push_back(bsfr_pkg::CSR_FLAG);
      val.push_back(next_cfg.flag_value);
      idx.push_back(bsfr_pkg::CSR_ESCAPE);
      val.push_back(next_cfg.escape_value);
      idx.push_back(bsfr_pkg::CSR_ADDRESS);
      val.push_back(next_cfg.address_value);
      if (poke_unused) begin
         idx.push_back(CSR_UNUSED);
         val.push_back(8'($urandom));
      end
      foreach (idx[i]) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx[i];
         csr_if.data  <= val[i];
         do @(posedge clock); while (!csr_if.ready);
         case (idx[i])
            bsfr_pkg::CSR_FLAG:    line_cfg.flag_value    = val[i];
            bsfr_pkg::CSR_ESCAPE:  line_cfg.escape_value  = val[i];
            bsfr_pkg::CSR_ADDRESS: line_cfg.address_value = val[i];
            default: ;
         endcase
      end
      csr_if.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------------------
   // Test sequence: reset, a directed part under the reset settings, then random phases
   // under several register settings, extremes among them. Between phases the sender
   // waits for every response.
   // ------------------------------------------------------------------------------------

   initial begin
      logic [7:0]        payload[$];
      bsfr_pkg::cfg_type next_cfg;
      logic [7:0]        v;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = bsfr_pkg::CSR_FLAG;
      csr_if.data    = 8'h00;

      line_cfg.flag_value    = bsfr_pkg::FLAG_RESET;
      line_cfg.escape_value  = bsfr_pkg::ESCAPE_RESET;
      line_cfg.address_value = bsfr_pkg::ADDRESS_RESET;
      decode_phase    = bsfr_pkg::PH_HUNT;
      frame_ctl       = 8'h00;
      held_byte       = 8'h00;
      held_valid      = 1'b0;
      escape_pending  = 1'b0;
      payload_xor     = 8'h00;
      delivered_count = '0;
      bytes_queued    = 0;
      bytes_accepted  = 0;
      errors          = 0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A good frame carrying both extreme byte values and both values that need stuffing.
      payload.push_back(8'h00);
      payload.push_back(8'hFF);
      payload.push_back(line_cfg.flag_value);
      payload.push_back(line_cfg.escape_value);
      send_frame(bsfr_pkg::CTRL_ZERO, payload, 1'b0);
      // A frame with the other control value and a wrong BCC2.
      payload.delete();
      payload.push_back(8'h55);
      send_frame(bsfr_pkg::CTRL_ONE, payload, 1'b1);
      // The closing flag comes right after BCC1, so there is neither data nor BCC2.
      send_header(bsfr_pkg::CTRL_ONE);
      send(line_cfg.flag_value);
      // An escape right before the closing flag.
      send_header(bsfr_pkg::CTRL_ZERO);
      send(8'h11);
      send(line_cfg.escape_value);
      send(line_cfg.flag_value);
      // Two escapes in a row, where the second one is data.
      send_header(bsfr_pkg::CTRL_ZERO);
      send(line_cfg.escape_value);
      send(line_cfg.escape_value);
      send(8'h00);
      send(line_cfg.flag_value);
      // A flag in place of the control byte and then of BCC1 restarts the header.
      send(line_cfg.flag_value);
      send(line_cfg.address_value);
      send(line_cfg.flag_value);
      send(line_cfg.address_value);
      send(bsfr_pkg::CTRL_ZERO);
      payload.delete();
      payload.push_back(8'hA5);
      send_frame(bsfr_pkg::CTRL_ONE, payload, 1'b0);
      // A wrong address, then a wrong control byte, then a wrong BCC1.
      send(line_cfg.flag_value);
      send(~line_cfg.address_value);
      send(line_cfg.flag_value);
      send(line_cfg.address_value);
      send(8'h20);
      send(line_cfg.flag_value);
      send(line_cfg.address_value);
      send(bsfr_pkg::CTRL_ONE);
      send(line_cfg.address_value ^ bsfr_pkg::CTRL_ZERO);
      wait_idle();

      // Random traffic under the reset settings. The long response hold falls in here.
      queue_random_phase(150);

      // Extreme settings, first with no idling on either side.
      req_idle_on            = 1'b0;
      rsp_idle_on            = 1'b0;
      next_cfg.flag_value    = 8'h00;
      next_cfg.escape_value  = 8'hFF;
      next_cfg.address_value = 8'hFF;
      load_config(next_cfg, 1'b1);
      queue_random_phase(150);

      req_idle_on            = 1'b1;
      rsp_idle_on            = 1'b1;
      next_cfg.flag_value    = 8'hFF;
      next_cfg.escape_value  = 8'h00;
      next_cfg.address_value = 8'h00;
      load_config(next_cfg, 1'b0);
      queue_random_phase(150);

      // The address equals the flag, so the address compare has to win in the header.
      v                      = 8'($urandom);
      next_cfg.flag_value    = v;
      next_cfg.escape_value  = v ^ 8'h01;
      next_cfg.address_value = v;
      load_config(next_cfg, 1'b1);
      queue_random_phase(100);

      // Fully random settings, with only the sender idling.
      rsp_idle_on            = 1'b0;
      next_cfg.flag_value    = 8'($urandom);
      next_cfg.escape_value  = 8'($urandom);
      next_cfg.address_value = 8'($urandom);
      load_config(next_cfg, 1'b0);
      queue_random_phase(100);

      // Back to the reset values for a last stretch of random traffic.
      req_idle_on            = 1'b1;
      rsp_idle_on            = 1'b1;
      next_cfg.flag_value    = bsfr_pkg::FLAG_RESET;
      next_cfg.escape_value  = bsfr_pkg::ESCAPE_RESET;
      next_cfg.address_value = bsfr_pkg::ADDRESS_RESET;
      load_config(next_cfg, 1'b1);
      queue_random_phase(50);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // This stops a run that hangs.
   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
